// ===== rtl/dma_region_range_table_core_defines.svh =====
// Assertion macros for the DMA region table.
// Used by dma_region_range_table_core; expects clk and rst_n in scope.
`ifndef DMA_REGION_RANGE_TABLE_CORE_DEFINES_SVH
`define DMA_REGION_RANGE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DRRT_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define DRRT_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== rtl/drrt_pkg.sv =====
// Shared types and codes for the DMA region table.
// No dependencies.
package drrt_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EXISTS    = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [63:0] area_length;
    logic [63:0] user_address;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] hit_base;
    logic [63:0] hit_length;
    logic [63:0] hit_user_address;
    logic [3:0]  hit_slot;
  } out_t;

  // One table slot as held in the RAM.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [63:0] user_address;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Compare result of one slot against the current request.
  typedef struct packed {
    logic contain;
    logic base_eq;
  } match_t;

endpackage

// ===== rtl/drrt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module drrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/drrt_match.sv =====
// Slot compare: exact base and 65-bit containment of an area.
// Depends on drrt_pkg.
module drrt_match (
  input  drrt_pkg::entry_t ent,
  input  logic [63:0]      address,
  input  logic [64:0]      area_end,
  input  logic             len_zero,
  output drrt_pkg::match_t m
);
  import drrt_pkg::*;

  logic [64:0] region_end;
  logic        base_eq;

  assign region_end = {1'b0, ent.base} + {1'b0, ent.length};
  assign base_eq    = (ent.base == address);

  assign m.base_eq = base_eq;
  // zero length: exact base; else base <= addr and region end covers area end
  assign m.contain = len_zero ? base_eq
                              : ((ent.base <= address) && (region_end >= area_end));

endmodule

// ===== rtl/dma_region_range_table_core.sv =====
// Top level of the DMA region table: control, valid bits, output register.
// Depends on drrt_pkg, drrt_ram, drrt_match and the assertion macro header.
`include "dma_region_range_table_core_defines.svh"

// A table of TABLE_ENTRIES mapped DMA regions (base, length, user address)
// serving add, find, remove and clear requests, one result item per request
// item. Slot contents sit in one RAM with a registered read; the valid bits
// are flip-flops, so reset and clear empty the table at once and no clearing
// pass is needed. Every request except clear reads all slots in order, one
// RAM read per cycle, and the lowest matching valid slot wins; an add goes to
// the lowest free slot. One item is worked on at a time: the single RAM read
// port is walked slot by slot, the read data of each slot is checked in a
// compare stage, and a finishing state builds the result once the output
// register is free; clear goes straight to the finishing state. The finished
// result sits in an output register, so the next item can be accepted while
// it waits to be taken. hit_slot carries the low 4 bits of the slot number.
module dma_region_range_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  drrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output drrt_pkg::out_t out_data
);
  import drrt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

  localparam logic [1:0] STATE_IDLE = 2'd0;
  localparam logic [1:0] STATE_SCAN = 2'd1;
  localparam logic [1:0] STATE_FIN  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  in_t                     item_r, item_nxt;
  logic [64:0]             area_end_r, area_end_nxt;
  logic                    len_zero_r, len_zero_nxt;
  logic [CW-1:0]           iss_cnt_r, iss_cnt_nxt;
  logic                    cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic                    hit_found_r, hit_found_nxt;
  logic [IW-1:0]           hit_idx_r, hit_idx_nxt;
  entry_t                  hit_ent_r, hit_ent_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [IW-1:0]           free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] vld_r, vld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r, out_data_nxt;

  logic                    accept;
  logic                    iss_pending;
  logic                    out_free;
  logic                    out_load;
  logic                    ram_we;
  logic [IW-1:0]           ram_wr_addr;
  entry_t                  ram_wr_ent;
  logic [ENTRY_W-1:0]      ram_rd_data;
  entry_t                  rd_ent;
  match_t                  m;
  logic                    slot_v;
  logic                    hit_now;

  assign in_stall    = (state_r != STATE_IDLE);
  assign accept      = in_valid && !in_stall;
  assign iss_pending = (state_r == STATE_SCAN) && (iss_cnt_r != CNT_END);
  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == STATE_FIN) && out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Writes happen only in the finishing cycle and the next item's reads start
  // after it, so a read never overlaps a write to the same slot.
  drrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_ent),
    .rd_addr (iss_cnt_r[IW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign rd_ent = entry_t'(ram_rd_data);

  drrt_match u_match (
    .ent      (rd_ent),
    .address  (item_r.address),
    .area_end (area_end_r),
    .len_zero (len_zero_r),
    .m        (m)
  );

  assign slot_v = vld_r[cmp_idx_r];

  always_comb begin
    case (item_r.req_type)
      REQ_ADD:    hit_now = m.contain || m.base_eq;
      REQ_FIND:   hit_now = m.contain;
      REQ_REMOVE: hit_now = m.base_eq;
      default:    hit_now = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    area_end_nxt   = area_end_r;
    len_zero_nxt   = len_zero_r;
    iss_cnt_nxt    = iss_cnt_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    vld_nxt        = vld_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_wr_addr    = free_idx_r;
    ram_wr_ent     = '{base: item_r.address, length: item_r.area_length,
                       user_address: item_r.user_address};

    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      STATE_IDLE: begin
        if (accept) begin
          item_nxt       = in_data;
          area_end_nxt   = {1'b0, in_data.address} + {1'b0, in_data.area_length};
          len_zero_nxt   = (in_data.area_length == 64'd0);
          iss_cnt_nxt    = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = (in_data.req_type == REQ_CLEAR) ? STATE_FIN : STATE_SCAN;
        end
      end

      STATE_SCAN: begin
        // issue stage: one slot read per cycle
        if (iss_pending) begin
          iss_cnt_nxt = iss_cnt_r + CW'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = iss_cnt_r[IW-1:0];
        end
        // compare stage: RAM data of the slot read last cycle
        if (cmp_v_r) begin
          if (slot_v && hit_now && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = cmp_idx_r;
            hit_ent_nxt   = rd_ent;
          end
          if (!slot_v && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = STATE_FIN;
          end
        end
      end

      STATE_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = STATE_IDLE;
          out_data_nxt  = '0;
          out_data_nxt.status = STS_NOT_FOUND;
          case (item_r.req_type)
            REQ_ADD: begin
              if (hit_found_r) begin
                out_data_nxt.status           = STS_EXISTS;
                out_data_nxt.hit_base         = hit_ent_r.base;
                out_data_nxt.hit_length       = hit_ent_r.length;
                out_data_nxt.hit_user_address = hit_ent_r.user_address;
                out_data_nxt.hit_slot         = 4'(hit_idx_r);
              end else if (free_found_r) begin
                ram_we                        = 1'b1;
                vld_nxt[free_idx_r]           = 1'b1;
                out_data_nxt.status           = STS_OK;
                out_data_nxt.hit_base         = item_r.address;
                out_data_nxt.hit_length       = item_r.area_length;
                out_data_nxt.hit_user_address = item_r.user_address;
                out_data_nxt.hit_slot         = 4'(free_idx_r);
              end else begin
                out_data_nxt.status = STS_FULL;
              end
            end
            REQ_FIND, REQ_REMOVE: begin
              if (hit_found_r) begin
                out_data_nxt.status           = STS_OK;
                out_data_nxt.hit_base         = hit_ent_r.base;
                out_data_nxt.hit_length       = hit_ent_r.length;
                out_data_nxt.hit_user_address = hit_ent_r.user_address;
                out_data_nxt.hit_slot         = 4'(hit_idx_r);
                if (item_r.req_type == REQ_REMOVE) begin
                  vld_nxt[hit_idx_r] = 1'b0;
                end
              end
            end
            default: begin
              // clear all
              out_data_nxt.status = STS_OK;
              vld_nxt             = '0;
            end
          endcase
        end
      end

      default: begin
        state_nxt = STATE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_IDLE;
      cmp_v_r     <= 1'b0;
      iss_cnt_r   <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    area_end_r   <= area_end_nxt;
    len_zero_r   <= len_zero_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_ent_r    <= hit_ent_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    out_data_r   <= out_data_nxt;
  end

  // A pending result is never overwritten.
  `DRRT_ASSERT_NOW(a_no_overwrite, out_load && out_valid_r, !out_stall, "result overwritten")

  // A successful add sets exactly one more valid bit.
  `DRRT_ASSERT_NEXT(a_add_one_slot, out_load && (item_r.req_type == REQ_ADD) && !hit_found_r && free_found_r, $countones(vld_r) == $past($countones(vld_r)) + 1, "add did not fill one slot")

  // Clear leaves the table empty.
  `DRRT_ASSERT_NEXT(a_clear_empty, out_load && (item_r.req_type == REQ_CLEAR), vld_r == '0, "clear left valid slots")

endmodule
